FILE: rtl/core/uart_rx_fifo_with_sticky_errors_assert.svh
// Assertion macros for the UART receive FIFO.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef UART_RX_FIFO_WITH_STICKY_ERRORS_ASSERT_SVH
`define UART_RX_FIFO_WITH_STICKY_ERRORS_ASSERT_SVH

// same-cycle implication
`define URXF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked on the following clock edge
`define URXF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/urxf_pkg.sv
// Shared types and constants of the UART receive FIFO.
// No dependencies.
package urxf_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int ERR_W     = 4;

	// bit positions in the error set
	localparam int ERR_PARITY_BIT   = 0;
	localparam int ERR_LINE_OVR_BIT = 1;
	localparam int ERR_FRAME_BIT    = 2;
	localparam int ERR_BUF_OVF_BIT  = 3;

	typedef enum logic [1:0] {
		CMD_RECV  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_FETCH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACK    = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_ERRORS = 2'd2,
		KIND_NODATA = 2'd3
	} kind_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] rx_byte;
		logic       byte_present;
		logic       parity_error;
		logic       line_overrun;
		logic       frame_error;
	} in_item_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data_byte;
		logic [ERR_W-1:0] error_flags;
		logic             data_ready;
	} out_item_t;

	// result of one item, minus the byte that the memory supplies
	typedef struct packed {
		kind_t            kind;
		logic [ERR_W-1:0] error_flags;
		logic             data_ready;
	} res_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ram_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic err_pending;
	} ring_stat_t;

endpackage

FILE: rtl/core/uart_rx_fifo_with_sticky_errors.sv
// Path: input register, then pointer and error update plus one byte-store access, then
// result register, which takes a result when the output advances. Throughput: one item
// per cycle while the output is not stalled by rsp_ready.
// Reset clears the pointers, the sticky error set and both valid flags; the
// byte store is not cleared and needs no clearing pass.
`include "uart_rx_fifo_with_sticky_errors_assert.svh"
// Top level of the UART receive FIFO with sticky errors.
// Depends on urxf_pkg, urxf_ctrl, urxf_ram and the assertion macro header.
module uart_rx_fifo_with_sticky_errors #(
	parameter int DEPTH = urxf_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  urxf_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output urxf_pkg::out_item_t rsp
);
	import urxf_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic          valid_s1, valid_s2;
	in_item_t      item_s1;
	res_t          res, res_s2;
	logic          advance, go;
	ram_ctl_t      ram_ctl;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, rd_data;
	ring_stat_t    stat;

	assign advance   = !valid_s2 || rsp_ready;
	assign req_ready = !valid_s1 || advance;
	assign go        = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
		if (go) begin
			res_s2 <= res;
		end
	end

	urxf_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.res    (res),
		.ram_ctl(ram_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.stat   (stat)
	);

	// read data lands alongside the result register
	urxf_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.ctl    (ram_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rsp_valid        = valid_s2;
	assign rsp.kind         = res_s2.kind;
	assign rsp.data_byte    = (res_s2.kind == KIND_DATA) ? rd_data : 8'h00;
	assign rsp.error_flags  = res_s2.error_flags;
	assign rsp.data_ready   = res_s2.data_ready;

	`URXF_ASSERT_NOW(a_byte_only_with_data, rsp_valid && rsp.kind != KIND_DATA,
		rsp.data_byte == 8'h00, "data byte set on a non-data result")
	`URXF_ASSERT_NOW(a_flags_only_with_errors, rsp_valid && rsp.kind != KIND_ERRORS,
		rsp.error_flags == '0, "error flags set on a non-error result")
	`URXF_ASSERT_NEXT(a_fetch_clears, go && item_s1.command == CMD_FETCH,
		!stat.err_pending, "sticky errors survived a fetch")
	`URXF_ASSERT_NOW(a_full_not_empty, stat.full, !stat.empty,
		"ring reports full and empty at once")

endmodule

FILE: rtl/core/urxf_ram.sv
// Byte store of the receive ring: one write port, one registered read port.
// Depends on urxf_pkg.
module urxf_ram #(
	parameter int DEPTH = urxf_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  urxf_pkg::ram_ctl_t ctl,
	input  logic [AW-1:0]      wr_addr,
	input  logic [7:0]         wr_data,
	input  logic [AW-1:0]      rd_addr,
	output logic [7:0]         rd_data
);
	import urxf_pkg::*;

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/core/urxf_ctrl.sv
// Ring pointers, sticky error set and per-item result decode.
// Depends on urxf_pkg.
module urxf_ctrl #(
	parameter int DEPTH = urxf_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  urxf_pkg::in_item_t   item,
	output urxf_pkg::res_t       res,
	output urxf_pkg::ram_ctl_t   ram_ctl,
	output logic [AW-1:0]        wr_addr,
	output logic [7:0]           wr_data,
	output logic [AW-1:0]        rd_addr,
	output urxf_pkg::ring_stat_t stat
);
	import urxf_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0]    rd_ptr_q, wr_ptr_q;
	logic [ERR_W-1:0] err_q;
	logic [AW-1:0]    rd_nxt, wr_nxt, rd_inc, wr_inc;
	logic [ERR_W-1:0] err_nxt, line_errs;
	logic             empty, full, wr_en;

	assign rd_inc = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
	assign wr_inc = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
	assign empty  = (rd_ptr_q == wr_ptr_q);
	assign full   = (wr_inc == rd_ptr_q);

	always_comb begin
		line_errs                   = '0;
		line_errs[ERR_PARITY_BIT]   = item.parity_error;
		line_errs[ERR_LINE_OVR_BIT] = item.line_overrun;
		line_errs[ERR_FRAME_BIT]    = item.frame_error;
	end

	always_comb begin
		rd_nxt          = rd_ptr_q;
		wr_nxt          = wr_ptr_q;
		err_nxt         = err_q;
		wr_en           = 1'b0;
		res.kind        = KIND_NODATA;
		res.error_flags = '0;
		unique case (item.command)
			CMD_RECV: begin
				res.kind = KIND_ACK;
				err_nxt  = err_q | line_errs;
				if (item.byte_present) begin
					if (full) begin
						err_nxt[ERR_BUF_OVF_BIT] = 1'b1;
					end else begin
						wr_en  = 1'b1;
						wr_nxt = wr_inc;
					end
				end
			end
			CMD_READ: begin
				// pending errors win over data
				if (err_q != '0) begin
					res.kind        = KIND_ERRORS;
					res.error_flags = err_q;
					err_nxt         = '0;
				end else if (!empty) begin
					res.kind = KIND_DATA;
					rd_nxt   = rd_inc;
				end
			end
			CMD_FETCH: begin
				res.kind        = KIND_ERRORS;
				res.error_flags = err_q;
				err_nxt         = '0;
			end
			default: begin
				res.kind = KIND_NODATA;
			end
		endcase
		res.data_ready = (err_nxt != '0) || (rd_nxt != wr_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			err_q    <= '0;
		end else if (go) begin
			rd_ptr_q <= rd_nxt;
			wr_ptr_q <= wr_nxt;
			err_q    <= err_nxt;
		end
	end

	assign ram_ctl.wr_en = go && wr_en;
	assign ram_ctl.rd_en = go;
	assign wr_addr       = wr_ptr_q;
	assign wr_data       = item.rx_byte;
	assign rd_addr       = rd_ptr_q;

	assign stat.empty       = empty;
	assign stat.full        = full;
	assign stat.err_pending = (err_q != '0);

endmodule
